// File: rtl/core/smdv_pkg.sv
// shared constants and types for the sign-magnitude delta varint encoder
// no dependencies
package smdv_pkg;

  // encoding mode register codes (code 3 behaves as delta)
  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_ZIGZAG = 2'd1;
  localparam logic [1:0] MODE_DELTA  = 2'd2;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxBytes = 3;

  // encoded form of one sample, ready for the byte serializer
  typedef struct packed {
    logic [2:0][ByteW-1:0] bytes;   // bytes[0] goes out first
    logic [1:0]            count;   // 1 to 3
  } enc_item_t;

endpackage

// File: rtl/core/sign_magnitude_delta_varint_encoder_top.sv
// sign-magnitude delta varint encoder, top level
// depends on smdv_pkg; no submodules
//
// Encodes 16-bit sign-magnitude samples (bit 15 set = positive) into a byte
// stream: raw little-endian in mode 0, zigzag varint in mode 1, and zigzag
// varint of the difference to the previous sample in mode 2 (and 3), with the
// predictor restarting at zero on first_in_row (tuser). A sample is taken into
// an input register; the byte serializer then sends one byte per cycle while
// m_axis_tready is high, so a sample takes 1 to 3 output bytes (2 in raw mode)
// and the sustained sample rate is set by the output byte count. The input
// register accepts the next sample while the serializer is still sending the
// current one. m_axis_tlast marks the final byte of each sample. The user must
// write encoding_mode through cfg_we_i/cfg_wdata_i only while idle (not enforced).
module sign_magnitude_delta_varint_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // encoding_mode
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] sample
  input  logic        s_axis_tuser,    // [0] first_in_row
  // byte output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tlast     // last
);

  localparam int unsigned EncW = smdv_pkg::SampleW + 2;

  logic [1:0]                    mode_q;
  logic [smdv_pkg::SampleW-1:0]  prev_q;
  logic                          in_valid_q;
  logic [smdv_pkg::SampleW-1:0]  in_sample_q;
  logic [smdv_pkg::SampleW-1:0]  in_pred_q;
  logic                          ser_valid_q;
  logic [2:0][smdv_pkg::ByteW-1:0] ser_bytes_q, ser_bytes_d;
  logic [1:0]                    ser_left_q, ser_left_d;

  logic                          s_fire, m_fire, ser_free, ser_load;
  logic [smdv_pkg::SampleW-1:0]  s_val;
  logic [smdv_pkg::SampleW-1:0]  q_val;
  logic signed [EncW-1:0]        enc;
  logic [EncW-1:0]               zz;
  smdv_pkg::enc_item_t           item;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = m_axis_tvalid && m_axis_tready;
  assign ser_free = !ser_valid_q || (m_fire && (ser_left_q == 2'd1));
  assign ser_load = ser_free && in_valid_q;
  assign s_axis_tready = !in_valid_q || ser_load;

  // sign-magnitude to two's complement for the incoming sample
  assign s_val = s_axis_tdata[15]
               ? {1'b0, s_axis_tdata[14:0]}
               : (~{1'b0, s_axis_tdata[14:0]} + 16'd1);

  // same conversion on the registered sample
  assign q_val = in_sample_q[15]
               ? {1'b0, in_sample_q[14:0]}
               : (~{1'b0, in_sample_q[14:0]} + 16'd1);

  // value to encode and its zigzag map
  always_comb begin
    if (mode_q == smdv_pkg::MODE_ZIGZAG) begin
      enc = EncW'($signed(q_val));
    end else begin
      enc = EncW'($signed(q_val)) - EncW'($signed(in_pred_q));
    end
    zz = {enc[EncW-2:0], 1'b0} ^ {EncW{enc[EncW-1]}};
  end

  // byte split of the registered sample
  always_comb begin
    item = '0;
    if (mode_q == smdv_pkg::MODE_RAW) begin
      item.bytes[0] = in_sample_q[7:0];
      item.bytes[1] = in_sample_q[15:8];
      item.count    = 2'd2;
    end else begin
      priority if (zz[EncW-1:14] != '0) begin
        item.count = 2'd3;
      end else if (zz[13:7] != '0) begin
        item.count = 2'd2;
      end else begin
        item.count = 2'd1;
      end
      item.bytes[0] = {item.count != 2'd1, zz[6:0]};
      item.bytes[1] = {item.count == 2'd3, zz[13:7]};
      item.bytes[2] = {4'd0, zz[17:14]};
    end
  end

  // serializer next state
  always_comb begin
    ser_bytes_d = ser_bytes_q;
    ser_left_d  = ser_left_q;
    if (ser_load) begin
      ser_bytes_d = item.bytes;
      ser_left_d  = item.count;
    end else if (m_fire && (ser_left_q != 2'd1)) begin
      ser_bytes_d = {smdv_pkg::ByteW'(0), ser_bytes_q[2], ser_bytes_q[1]};
      ser_left_d  = ser_left_q - 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= smdv_pkg::MODE_RAW;
      prev_q      <= '0;
      in_valid_q  <= 1'b0;
      ser_valid_q <= 1'b0;
      ser_left_q  <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (s_fire) begin
        prev_q <= s_val;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (ser_free) begin
        ser_valid_q <= in_valid_q;
      end
      ser_left_q <= ser_left_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_sample_q <= s_axis_tdata;
      in_pred_q   <= s_axis_tuser ? '0 : prev_q;
    end
    ser_bytes_q <= ser_bytes_d;
  end

  assign m_axis_tvalid = ser_valid_q;
  assign m_axis_tdata  = ser_bytes_q[0];
  assign m_axis_tlast  = (ser_left_q == 2'd1);

  // serializer always holds at least one byte when valid
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q |-> (ser_left_q != 2'd0))
    else $error("serializer valid with no bytes left");

  // raw mode never needs more than two bytes
  a_raw_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_load && (mode_q == smdv_pkg::MODE_RAW)) |-> (item.count == 2'd2))
    else $error("raw sample not split into two bytes");

  // output drains after the final byte when nothing is queued
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast && !in_valid_q) |=> !m_axis_tvalid)
    else $error("output still valid after final byte with empty input stage");

endmodule
